### rtl/dtfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the delimited text field parser.
package dtfp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int SEP_BITS  = 9;
    localparam int COL_BITS  = 16;
    localparam int IDX_BITS  = 3;

    localparam logic [COL_BITS-1:0] COL_MAX = '1;

    // Separator reset values; 256 disables a separator
    localparam logic [SEP_BITS-1:0] UNIT_SEP_A_RST   = 9'd32;
    localparam logic [SEP_BITS-1:0] UNIT_SEP_B_RST   = 9'd9;
    localparam logic [SEP_BITS-1:0] RECORD_SEP_RST   = 9'd10;
    localparam logic [SEP_BITS-1:0] GROUP_SEP_RST    = 9'd256;
    localparam logic [SEP_BITS-1:0] TABLE_SEP_RST    = 9'd12;
    localparam logic [SEP_BITS-1:0] COMMENT_CHAR_RST = 9'd35;

    typedef enum logic [IDX_BITS-1:0] {
        REG_UNIT_SEP_A          = 3'd0,
        REG_UNIT_SEP_B          = 3'd1,
        REG_RECORD_SEP          = 3'd2,
        REG_GROUP_SEP           = 3'd3,
        REG_TABLE_SEP           = 3'd4,
        REG_COMMENT_CHAR        = 3'd5,
        REG_ALLOW_EMPTY_FIELDS  = 3'd6,
        REG_ALLOW_EMPTY_RECORDS = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_SKIP       = 3'd0,
        KIND_FIELD_CHAR = 3'd1,
        KIND_FIELD_END  = 3'd2,
        KIND_RECORD_END = 3'd3,
        KIND_TABLE_CLR  = 3'd4,
        KIND_COMMENT    = 3'd5
    } kind_t;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 is_unit;
        logic                 is_rec;
        logic                 is_table;
        logic                 is_comment;
        logic                 allow_empty_fields;
        logic                 allow_empty_records;
    } item_t;

endpackage

### rtl/dtfp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dtfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dtfp_front.sv
`timescale 1ns / 1ps
// Front end: separator registers, byte classification and input register.
module dtfp_front import dtfp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [IDX_BITS-1:0]  cfg_index,
    input  logic [SEP_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_BITS-1:0] in_byte,
    output logic                 f_valid,
    output item_t                f_item,
    input  logic                 f_ready
);

    logic [SEP_BITS-1:0] unit_a_reg, unit_b_reg, rec_reg, group_reg, table_reg, comment_reg;
    logic                aef_reg, aer_reg;
    logic                valid_reg;
    item_t               item_reg;
    item_t               item_next;
    logic [SEP_BITS-1:0] b9;

    assign in_ready = !valid_reg || f_ready;
    assign f_valid  = valid_reg;
    assign f_item   = item_reg;
    assign b9       = {1'b0, in_byte};

    always_comb
    begin
        item_next.value               = in_byte;
        item_next.is_unit             = (unit_a_reg == b9) || (unit_b_reg == b9);
        item_next.is_rec              = (rec_reg == b9) || (group_reg == b9);
        item_next.is_table            = (table_reg == b9);
        item_next.is_comment          = (comment_reg == b9);
        item_next.allow_empty_fields  = aef_reg;
        item_next.allow_empty_records = aer_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_a_reg  <= UNIT_SEP_A_RST;
            unit_b_reg  <= UNIT_SEP_B_RST;
            rec_reg     <= RECORD_SEP_RST;
            group_reg   <= GROUP_SEP_RST;
            table_reg   <= TABLE_SEP_RST;
            comment_reg <= COMMENT_CHAR_RST;
            aef_reg     <= 1'b0;
            aer_reg     <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_UNIT_SEP_A:          unit_a_reg  <= cfg_data;
                    REG_UNIT_SEP_B:          unit_b_reg  <= cfg_data;
                    REG_RECORD_SEP:          rec_reg     <= cfg_data;
                    REG_GROUP_SEP:           group_reg   <= cfg_data;
                    REG_TABLE_SEP:           table_reg   <= cfg_data;
                    REG_COMMENT_CHAR:        comment_reg <= cfg_data;
                    REG_ALLOW_EMPTY_FIELDS:  aef_reg     <= cfg_data[0];
                    REG_ALLOW_EMPTY_RECORDS: aer_reg     <= cfg_data[0];
                    default:                 aef_reg     <= aef_reg;
                endcase
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/dtfp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back.
module dtfp_queue import dtfp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop,
    output item_t pop_item
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    item_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/dtfp_back.sv
`timescale 1ns / 1ps
// Back end: parse state, row/column tracking, column width store, result register.
module dtfp_back import dtfp_pkg::*; #(
    parameter int MAX_COLUMNS = 64,
    parameter int ROW_BITS    = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             kind,
    output logic [BYTE_BITS-1:0]   out_byte,
    output logic [ROW_BITS-1:0]    row_index,
    output logic [COL_BITS-1:0]    column_index,
    output logic [LENGTH_BITS-1:0] field_position,
    output logic [LENGTH_BITS-1:0] column_width,
    output logic                   column_overflow
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [COL_BITS:0]      MAX_COL_EXT = (COL_BITS+1)'(MAX_COLUMNS);
    localparam logic [ROW_BITS-1:0]    ROW_MAX     = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX     = '1;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_FIELD,
        MODE_COMMENT
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [LENGTH_BITS-1:0] flen_reg, flen_next;
    logic                   rhd_reg, rhd_next;
    // width of the current column and of column 0, kept beside the RAM
    logic [LENGTH_BITS-1:0] curw_reg, curw_next;
    logic [LENGTH_BITS-1:0] w0_reg, w0_next;
    logic [MAX_COLUMNS-1:0] wvalid_reg, wvalid_next;
    logic                   out_valid_reg;

    kind_t                  res_kind;
    logic [ROW_BITS-1:0]    res_row;
    logic [COL_BITS-1:0]    res_col;
    logic [LENGTH_BITS-1:0] res_pos, res_width;

    logic                   fire;
    logic [COL_BITS-1:0]    col_inc;
    logic [ROW_BITS-1:0]    row_inc;
    logic [COL_BITS:0]      colp1;
    logic                   cur_ok, next_ok;
    logic [AW-1:0]          cidx, nidx, raddr;
    logic [COL_BITS-1:0]    rsum;
    logic [LENGTH_BITS-1:0] rdata, next_w, flen_base, fl1, w_new;
    logic                   we;

    assign fire      = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = fire;
    assign out_valid = out_valid_reg;

    assign col_inc = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
    assign row_inc = (row_reg == ROW_MAX) ? row_reg : row_reg + 1'b1;
    assign colp1   = {1'b0, col_reg} + 1'b1;
    assign cur_ok  = ({1'b0, col_reg} < MAX_COL_EXT);
    assign next_ok = (colp1 < MAX_COL_EXT);
    assign cidx    = col_reg[AW-1:0];
    assign nidx    = colp1[AW-1:0];
    // RAM data for the column after the current one, prefetched through the registered read port
    assign next_w  = (next_ok && wvalid_reg[nidx]) ? rdata : '0;

    assign flen_base = (mode_reg == MODE_FIELD) ? flen_reg : '0;
    assign fl1       = (flen_base == LEN_MAX) ? flen_base : flen_base + 1'b1;
    assign w_new     = (fl1 > curw_reg) ? fl1 : curw_reg;

    // prefetch address follows the column that holds after this edge
    assign rsum  = col_next + 1'b1;
    assign raddr = rsum[AW-1:0];

    dtfp_ram #(
        .WIDTH (LENGTH_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_width_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cidx),
        .wdata (w_new),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        flen_next   = flen_reg;
        rhd_next    = rhd_reg;
        curw_next   = curw_reg;
        w0_next     = w0_reg;
        wvalid_next = wvalid_reg;
        we          = 1'b0;
        res_kind    = KIND_SKIP;
        res_row     = row_reg;
        res_col     = col_reg;
        res_pos     = '0;
        res_width   = curw_reg;

        if (fire)
        begin
            if (q_item.is_table)
            begin
                row_next    = '0;
                col_next    = '0;
                flen_next   = '0;
                rhd_next    = 1'b0;
                curw_next   = '0;
                w0_next     = '0;
                wvalid_next = '0;
                mode_next   = (mode_reg == MODE_FIELD) ? MODE_FIELD : MODE_START;
                res_kind    = KIND_TABLE_CLR;
                res_row     = '0;
                res_col     = '0;
                res_width   = '0;
            end
            else if (mode_reg == MODE_COMMENT)
            begin
                res_kind = KIND_COMMENT;
                if (q_item.is_rec)
                begin
                    if (rhd_reg)
                    begin
                        row_next = row_inc;
                        rhd_next = 1'b0;
                        res_kind = KIND_RECORD_END;
                    end
                    col_next  = '0;
                    curw_next = w0_reg;
                    mode_next = MODE_START;
                end
            end
            else if (mode_reg == MODE_START && q_item.is_comment)
            begin
                mode_next = MODE_COMMENT;
                res_kind  = KIND_COMMENT;
            end
            else if (mode_reg == MODE_START && q_item.is_rec)
            begin
                if (col_reg != '0 || q_item.allow_empty_records)
                begin
                    row_next = row_inc;
                    rhd_next = 1'b0;
                    res_kind = KIND_RECORD_END;
                end
                col_next  = '0;
                curw_next = w0_reg;
            end
            else if (mode_reg == MODE_START && q_item.is_unit)
            begin
                if (q_item.allow_empty_fields)
                begin
                    col_next  = col_inc;
                    curw_next = next_w;
                    res_kind  = KIND_FIELD_END;
                end
            end
            else
            begin
                rhd_next = 1'b1;
                if (q_item.is_rec || q_item.is_unit)
                begin
                    res_pos   = flen_base;
                    flen_next = '0;
                    mode_next = MODE_START;
                    if (q_item.is_unit)
                    begin
                        col_next  = col_inc;
                        curw_next = next_w;
                        res_kind  = KIND_FIELD_END;
                    end
                    else
                    begin
                        row_next  = row_inc;
                        rhd_next  = 1'b0;
                        col_next  = '0;
                        curw_next = w0_reg;
                        res_kind  = KIND_RECORD_END;
                    end
                end
                else
                begin
                    mode_next = MODE_FIELD;
                    flen_next = fl1;
                    res_pos   = fl1;
                    res_kind  = KIND_FIELD_CHAR;
                    if (cur_ok)
                    begin
                        we                = 1'b1;
                        wvalid_next[cidx] = 1'b1;
                        curw_next         = w_new;
                        res_width         = w_new;
                        if (col_reg == '0)
                        begin
                            w0_next = w_new;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            row_reg       <= '0;
            col_reg       <= '0;
            flen_reg      <= '0;
            rhd_reg       <= 1'b0;
            curw_reg      <= '0;
            w0_reg        <= '0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            flen_reg   <= flen_next;
            rhd_reg    <= rhd_next;
            curw_reg   <= curw_next;
            w0_reg     <= w0_next;
            wvalid_reg <= wvalid_next;
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind            <= res_kind;
            out_byte        <= q_item.value;
            row_index       <= res_row;
            column_index    <= res_col;
            field_position  <= res_pos;
            column_width    <= res_width;
            // flag follows the reported column, which a table clear forces to 0
            column_overflow <= ({1'b0, res_col} >= MAX_COL_EXT);
        end
    end

endmodule

### rtl/delimited_text_field_parser_top.sv
`timescale 1ns / 1ps
// Top level of the delimited text field parser.
//
// Usage: one text byte enters on in_valid/in_ready/in_byte; one result item
// leaves per byte on out_valid/out_ready with kind, out_byte, row_index,
// column_index, field_position, column_width and column_overflow.
// Separators and the empty-field/empty-record flags are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the block is idle (not enforced).
// Path: an accepted item passes the front register, the queue and the result
// register, in that order.
// Throughput: one item per cycle, sustained while out_ready stays high. The
// pace is set by the back end; the width RAM read for the next column is issued
// from the column value about to be registered, so column changes never stall.
// Reset: separators return to their defaults, parse state, row, column and
// field length clear, and every column width reads as zero.
// Receiver stall: the result register holds; the two-entry queue and the
// front register fill, then in_ready drops. Nothing is dropped or repeated.
// A table separator clears widths and position with no clearing pass: the
// per-column valid bits clear in the same cycle.
module delimited_text_field_parser_top import dtfp_pkg::*; #(
    parameter int MAX_COLUMNS = 64,
    parameter int ROW_BITS    = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [IDX_BITS-1:0]    cfg_index,
    input  logic [SEP_BITS-1:0]    cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_BITS-1:0]   in_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             kind,
    output logic [BYTE_BITS-1:0]   out_byte,
    output logic [ROW_BITS-1:0]    row_index,
    output logic [COL_BITS-1:0]    column_index,
    output logic [LENGTH_BITS-1:0] field_position,
    output logic [LENGTH_BITS-1:0] column_width,
    output logic                   column_overflow
);

    // front to queue
    logic  f_valid, f_ready;
    item_t f_item;
    // queue to back
    logic  q_valid, q_pop;
    item_t q_item;

    dtfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .f_valid   (f_valid),
        .f_item    (f_item),
        .f_ready   (f_ready)
    );

    dtfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    dtfp_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_BITS    (ROW_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .out_byte        (out_byte),
        .row_index       (row_index),
        .column_index    (column_index),
        .field_position  (field_position),
        .column_width    (column_width),
        .column_overflow (column_overflow)
    );

endmodule

### rtl/dtfp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the delimited text field parser, with its bind.
module dtfp_checker import dtfp_pkg::*; #(
    parameter int MAX_COLUMNS = 64,
    parameter int ROW_BITS    = 24,
    parameter int LENGTH_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             kind,
    input logic [BYTE_BITS-1:0]   out_byte,
    input logic [ROW_BITS-1:0]    row_index,
    input logic [COL_BITS-1:0]    column_index,
    input logic [LENGTH_BITS-1:0] field_position,
    input logic [LENGTH_BITS-1:0] column_width,
    input logic                   column_overflow
);

    localparam logic [COL_BITS:0] MAX_COL_EXT = (COL_BITS+1)'(MAX_COLUMNS);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(row_index) && $stable(column_index) && $stable(field_position)
            && $stable(column_width) && $stable(column_overflow))
        else $error("result changed while stalled");

    a_table_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TABLE_CLR |-> row_index == '0 && column_index == '0
            && field_position == '0 && column_width == '0)
        else $error("table clear item with nonzero position");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (column_overflow == ({1'b0, column_index} >= MAX_COL_EXT))
            && (!column_overflow || column_width == '0))
        else $error("column overflow flag or width wrong");

    a_char_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FIELD_CHAR && !column_overflow
            |-> field_position != '0 && column_width >= field_position)
        else $error("column width below field length");

endmodule

bind delimited_text_field_parser_top dtfp_checker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ROW_BITS    (ROW_BITS),
    .LENGTH_BITS (LENGTH_BITS)
) u_dtfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_byte        (out_byte),
    .row_index       (row_index),
    .column_index    (column_index),
    .field_position  (field_position),
    .column_width    (column_width),
    .column_overflow (column_overflow)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the delimited text field parser: directed, long-row and random items.
module tb_top;
    import dtfp_pkg::*;

    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 24;
    localparam int LEN_W    = 16;

    // One result item as the block reports it
    typedef struct packed {
        logic [2:0]           kind_code;
        logic [BYTE_BITS-1:0] echo;
        logic [ROW_W-1:0]     row;
        logic [COL_BITS-1:0]  col;
        logic [LEN_W-1:0]     pos;
        logic [LEN_W-1:0]     width;
        logic                 ovf;
    } token_t;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_FIELD,
        SCAN_COMMENT
    } scan_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [SEP_BITS-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_BITS-1:0]  in_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            kind;
    logic [BYTE_BITS-1:0]  out_byte;
    logic [ROW_W-1:0]      row_index;
    logic [COL_BITS-1:0]   column_index;
    logic [LEN_W-1:0]      field_position;
    logic [LEN_W-1:0]      column_width;
    logic                  column_overflow;

    delimited_text_field_parser_top #(
        .MAX_COLUMNS (MAX_COLS),
        .ROW_BITS    (ROW_W),
        .LENGTH_BITS (LEN_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .out_byte        (out_byte),
        .row_index       (row_index),
        .column_index    (column_index),
        .field_position  (field_position),
        .column_width    (column_width),
        .column_overflow (column_overflow)
    );

    // Tokeniser state mirrored on the testbench side
    logic [SEP_BITS-1:0] cfg_shadow [8];
    scan_mode_t          scan_mode;
    logic [ROW_W-1:0]    row_cnt;
    logic [COL_BITS-1:0] col_cnt;
    logic [LEN_W-1:0]    field_len;
    logic                row_has_data;
    logic [LEN_W-1:0]    width_mem [MAX_COLS];
    logic                col_seen [MAX_COLS];

    token_t pending_tokens [$];

    bit tx_gap_on;
    bit rx_stall_on;
    int stall_left;
    int bytes_sent;
    int counted_items;
    int results_checked;
    int mismatches;
    int settings_used;
    int kinds_seen [8];

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Generous fixed limit on the whole run
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Gap length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver back-pressure, updated on the falling edge
    initial begin
        out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (rx_stall_on && $urandom_range(0, 5) == 0)
                stall_left = idle_len();
            out_ready <= (stall_left == 0);
        end
    end

    function automatic logic [LEN_W-1:0] width_at(input logic [COL_BITS-1:0] c);
        if (c < MAX_COLS && col_seen[c])
            return width_mem[c];
        return '0;
    endfunction

    function automatic void advance_row();
        if (row_cnt != '1)
            row_cnt++;
        row_has_data = 1'b0;
    endfunction

    function automatic void clear_tokeniser();
        scan_mode = SCAN_START;
        row_cnt = '0;
        col_cnt = '0;
        field_len = '0;
        row_has_data = 1'b0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            col_seen[i] = 1'b0;
            width_mem[i] = '0;
        end
        cfg_shadow[REG_UNIT_SEP_A] = UNIT_SEP_A_RST;
        cfg_shadow[REG_UNIT_SEP_B] = UNIT_SEP_B_RST;
        cfg_shadow[REG_RECORD_SEP] = RECORD_SEP_RST;
        cfg_shadow[REG_GROUP_SEP] = GROUP_SEP_RST;
        cfg_shadow[REG_TABLE_SEP] = TABLE_SEP_RST;
        cfg_shadow[REG_COMMENT_CHAR] = COMMENT_CHAR_RST;
        cfg_shadow[REG_ALLOW_EMPTY_FIELDS] = '0;
        cfg_shadow[REG_ALLOW_EMPTY_RECORDS] = '0;
    endfunction

    // Classify one byte and move the mirrored state on
    function automatic token_t tokenize_byte(input logic [BYTE_BITS-1:0] b);
        token_t t;
        logic [SEP_BITS-1:0] bx;
        logic is_unit, is_rec, is_table, is_cmt;
        logic [LEN_W-1:0] w;
        bx = {1'b0, b};
        is_unit = (cfg_shadow[REG_UNIT_SEP_A] == bx) || (cfg_shadow[REG_UNIT_SEP_B] == bx);
        is_rec = (cfg_shadow[REG_RECORD_SEP] == bx) || (cfg_shadow[REG_GROUP_SEP] == bx);
        is_table = (cfg_shadow[REG_TABLE_SEP] == bx);
        is_cmt = (cfg_shadow[REG_COMMENT_CHAR] == bx);
        t.kind_code = KIND_SKIP;
        t.echo = b;
        t.row = row_cnt;
        t.col = col_cnt;
        t.pos = '0;
        if (is_table)
        begin
            for (int i = 0; i < MAX_COLS; i++)
                col_seen[i] = 1'b0;
            row_cnt = '0;
            col_cnt = '0;
            field_len = '0;
            row_has_data = 1'b0;
            if (scan_mode != SCAN_FIELD)
                scan_mode = SCAN_START;
            t.kind_code = KIND_TABLE_CLR;
            t.row = '0;
            t.col = '0;
        end
        else if (scan_mode == SCAN_COMMENT)
        begin
            t.kind_code = KIND_COMMENT;
            if (is_rec)
            begin
                if (row_has_data)
                begin
                    advance_row();
                    t.kind_code = KIND_RECORD_END;
                end
                col_cnt = '0;
                scan_mode = SCAN_START;
            end
        end
        else if (scan_mode == SCAN_START && is_cmt)
        begin
            scan_mode = SCAN_COMMENT;
            t.kind_code = KIND_COMMENT;
        end
        else if (scan_mode == SCAN_START && is_rec)
        begin
            if (col_cnt != '0 || cfg_shadow[REG_ALLOW_EMPTY_RECORDS][0])
            begin
                advance_row();
                t.kind_code = KIND_RECORD_END;
            end
            col_cnt = '0;
        end
        else if (scan_mode == SCAN_START && is_unit)
        begin
            if (cfg_shadow[REG_ALLOW_EMPTY_FIELDS][0])
            begin
                if (col_cnt != COL_MAX)
                    col_cnt++;
                t.kind_code = KIND_FIELD_END;
            end
        end
        else
        begin
            if (scan_mode != SCAN_FIELD)
            begin
                scan_mode = SCAN_FIELD;
                field_len = '0;
            end
            row_has_data = 1'b1;
            if (is_rec || is_unit)
            begin
                t.pos = field_len;
                field_len = '0;
                if (is_unit)
                begin
                    if (col_cnt != COL_MAX)
                        col_cnt++;
                    t.kind_code = KIND_FIELD_END;
                end
                else
                begin
                    advance_row();
                    col_cnt = '0;
                    t.kind_code = KIND_RECORD_END;
                end
                scan_mode = SCAN_START;
            end
            else
            begin
                if (field_len != '1)
                    field_len++;
                if (col_cnt < MAX_COLS)
                begin
                    w = width_at(col_cnt);
                    width_mem[col_cnt] = (field_len > w) ? field_len : w;
                    col_seen[col_cnt] = 1'b1;
                end
                t.pos = field_len;
                t.kind_code = KIND_FIELD_CHAR;
            end
        end
        t.width = width_at(t.col);
        t.ovf = (t.col >= MAX_COLS);
        return t;
    endfunction

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        token_t got;
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {kind, out_byte, row_index, column_index, field_position,
                   column_width, column_overflow};
            results_checked++;
            kinds_seen[kind]++;
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d byte=%02h at %0t",
                             got.kind_code, got.echo, $realtime);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got.kind_code !== want.kind_code || got.echo !== want.echo
                    || got.row !== want.row || got.col !== want.col
                    || got.pos !== want.pos || got.width !== want.width
                    || got.ovf !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result %0d at %0t", results_checked, $realtime);
                        $display("  exp kind=%0d byte=%02h row=%0d col=%0d pos=%0d width=%0d ovf=%0b",
                                 want.kind_code, want.echo, want.row, want.col,
                                 want.pos, want.width, want.ovf);
                        $display("  got kind=%0d byte=%02h row=%0d col=%0d pos=%0d width=%0d ovf=%0b",
                                 got.kind_code, got.echo, got.row, got.col,
                                 got.pos, got.width, got.ovf);
                    end
                end
            end
        end
    end

    // Register write; only called while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [SEP_BITS-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_shadow[idx] = (idx == REG_ALLOW_EMPTY_FIELDS || idx == REG_ALLOW_EMPTY_RECORDS)
                          ? {8'd0, value[0]} : value;
    endtask

    // Offer one item; valid stays up between back-to-back items
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        int gap;
        token_t t;
        gap = (tx_gap_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        t = tokenize_byte(b);
        pending_tokens.insert(pending_tokens.size(), t);
        bytes_sent++;
        if (t.kind_code != KIND_SKIP)
            counted_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Let the block go idle: no valid, every result in, plus the pipeline depth
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_default_separators();
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        settings_used++;
        // fields, record end, empty record and doubled space skipped
        send_text("ab c\t\n\n  ");
        // comment on an empty row, then a comment after data in the row
        send_text("#x\nd #z\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        // table clear from inside a field
        send_byte(8'h0C);
        send_text("e\n");
        wait_idle();
    endtask

    task automatic test_special_cases();
        settings_used++;
        write_reg(REG_UNIT_SEP_A, 9'd0);
        write_reg(REG_UNIT_SEP_B, 9'd255);
        write_reg(REG_RECORD_SEP, 9'd10);
        write_reg(REG_GROUP_SEP, 9'd30);
        write_reg(REG_TABLE_SEP, 9'd12);
        write_reg(REG_COMMENT_CHAR, 9'd35);
        write_reg(REG_ALLOW_EMPTY_FIELDS, 9'd1);
        write_reg(REG_ALLOW_EMPTY_RECORDS, 9'd1);
        // empty fields counted, empty record advances the row
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("x");
        send_byte(8'h00);
        send_text("\n\nq");
        send_byte(8'h1E);
        // comment ended by the group separator, row empty then with data
        send_text("#c");
        send_byte(8'h1E);
        send_text("a");
        send_byte(8'h00);
        send_text("#z\n");
        // table clear in field, comment and start modes
        send_text("q");
        send_byte(8'h0C);
        send_text("r\n#");
        send_byte(8'h0C);
        send_text("k\n");
        send_byte(8'h0C);
        wait_idle();
        // record, group and first unit separators disabled, two with all nine data bits set
        settings_used++;
        write_reg(REG_RECORD_SEP, 9'd511);
        write_reg(REG_GROUP_SEP, 9'd256);
        write_reg(REG_UNIT_SEP_A, 9'd511);
        send_text("y\n");
        send_byte(8'h1E);
        wait_idle();
    endtask

    // A long field, then a row running past the tracked columns; no idling here
    task automatic test_long_rows();
        tx_gap_on = 1'b0;
        rx_stall_on = 1'b0;
        settings_used++;
        write_reg(REG_UNIT_SEP_A, 9'd32);
        write_reg(REG_UNIT_SEP_B, 9'd9);
        write_reg(REG_RECORD_SEP, 9'd10);
        write_reg(REG_ALLOW_EMPTY_FIELDS, 9'd0);
        send_text("\n");
        repeat (200) send_byte("w");
        send_text(" ");
        wait_idle();
        write_reg(REG_ALLOW_EMPTY_FIELDS, 9'd1);
        repeat (MAX_COLS + 8) send_byte(" ");
        send_text("z \n");
        wait_idle();
    endtask

    function automatic logic [SEP_BITS-1:0] rand_sep();
        logic [7:0] pool [8];
        int r;
        pool = '{8'h20, 8'h09, 8'h2C, 8'h3B, 8'h0A, 8'h7C, 8'h23, 8'h0C};
        r = $urandom_range(0, 9);
        if (r < 2)
            return 9'h100 | 9'($urandom_range(0, 255));
        if (r < 8)
            return {1'b0, pool[$urandom_range(0, 7)]};
        return 9'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    // Mostly well-formed text for the current separators, some noise
    function automatic logic [BYTE_BITS-1:0] pick_stream_byte();
        int r;
        logic [SEP_BITS-1:0] s;
        r = $urandom_range(0, 99);
        s = 9'h100;
        if (r < 12)
            s = $urandom_range(0, 1) ? cfg_shadow[REG_UNIT_SEP_A] : cfg_shadow[REG_UNIT_SEP_B];
        else if (r < 20)
            s = $urandom_range(0, 1) ? cfg_shadow[REG_RECORD_SEP] : cfg_shadow[REG_GROUP_SEP];
        else if (r < 24)
            s = cfg_shadow[REG_COMMENT_CHAR];
        else if (r < 25)
            s = cfg_shadow[REG_TABLE_SEP];
        else if (r < 33)
            s = 9'($urandom_range(0, 255));
        if (s[8])
            return pick_letter();
        return s[7:0];
    endfunction

    task automatic test_random_text();
        int target;
        int r;
        logic [SEP_BITS-1:0] fsep;
        for (int phase = 0; phase < 6; phase++)
        begin
            tx_gap_on = phase[0];
            rx_stall_on = phase[1];
            settings_used++;
            write_reg(REG_UNIT_SEP_A, rand_sep());
            write_reg(REG_UNIT_SEP_B, rand_sep());
            write_reg(REG_RECORD_SEP, rand_sep());
            write_reg(REG_GROUP_SEP, rand_sep());
            write_reg(REG_TABLE_SEP, rand_sep());
            write_reg(REG_COMMENT_CHAR, rand_sep());
            write_reg(REG_ALLOW_EMPTY_FIELDS, 9'($urandom_range(0, 1)));
            write_reg(REG_ALLOW_EMPTY_RECORDS, 9'($urandom_range(0, 1)));
            fsep = cfg_shadow[REG_UNIT_SEP_A][8] ? cfg_shadow[REG_UNIT_SEP_B]
                                                 : cfg_shadow[REG_UNIT_SEP_A];
            target = counted_items + 170;
            while (counted_items < target)
            begin
                r = $urandom_range(0, 199);
                if (r == 0)
                    // one long field
                    repeat ($urandom_range(20, 120)) send_byte(pick_letter());
                else if (r == 1)
                begin
                    // a wide row, running past the tracked columns
                    repeat ($urandom_range(60, 80))
                    begin
                        send_byte(pick_letter());
                        if (!fsep[8])
                            send_byte(fsep[7:0]);
                    end
                end
                else
                    send_byte(pick_stream_byte());
            end
            wait_idle();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_byte = '0;
        tx_gap_on = 1'b0;
        rx_stall_on = 1'b0;
        bytes_sent = 0;
        counted_items = 0;
        results_checked = 0;
        mismatches = 0;
        settings_used = 0;
        for (int i = 0; i < 8; i++)
            kinds_seen[i] = 0;
        clear_tokeniser();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_separators();
        test_special_cases();
        test_long_rows();
        test_random_text();

        mismatches += pending_tokens.size();
        $display("Covered %0d bytes (%0d not skipped) under %0d register settings, %0d results checked",
                 bytes_sent, counted_items, settings_used, results_checked);
        $display("Kinds: skip %0d, char %0d, field end %0d, record end %0d, clear %0d, comment %0d",
                 kinds_seen[KIND_SKIP], kinds_seen[KIND_FIELD_CHAR], kinds_seen[KIND_FIELD_END],
                 kinds_seen[KIND_RECORD_END], kinds_seen[KIND_TABLE_CLR], kinds_seen[KIND_COMMENT]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
